FILE: hw/rtl/vtd_pkg.sv
package vtd_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned MatrixDim = 4;
  localparam int unsigned NumCoef = MatrixDim * MatrixDim;
  localparam int unsigned CoefIdxW = $clog2(NumCoef);

  localparam logic ActLoad = 1'b0;
  localparam logic ActXform = 1'b1;

  localparam logic signed [31:0] Sat32Max = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Sat32Min = 32'sh8000_0000;

  typedef struct packed {
    logic action;
    logic [3:0] coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } vtd_in_t;

  typedef struct packed {
    logic signed [31:0] hom_x;
    logic signed [31:0] hom_y;
    logic signed [31:0] hom_z;
    logic signed [31:0] hom_w;
    logic signed [31:0] proj_x;
    logic signed [31:0] proj_y;
    logic signed [31:0] proj_z;
    logic w_zero;
  } vtd_out_t;

  // Point queued between the front end and the compute engine.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vtd_pt_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'(signed'(Sat32Max))) r = Sat32Max;
    else if (v < 66'(signed'(Sat32Min))) r = Sat32Min;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: hw/rtl/vtd_front.sv
// Front end: loads coefficients into the matrix store and queues transform points.
module vtd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  vtd_pkg::vtd_in_t in_data,
  output logic             q_valid,
  input  logic             q_pop,
  output vtd_pkg::vtd_pt_t q_data,
  input  logic             mac_busy,
  input  logic [3:0]       rd_idx,
  output logic signed [31:0] rd_data
);
  import vtd_pkg::*;

  localparam int unsigned QDepth = 2;

  logic signed [31:0] mat_r [NumCoef];
  vtd_pt_t q_mem_r [QDepth];
  logic wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic acc, push;

  // A load waits until every queued point has read its coefficients, so each
  // transform sees the matrix as it stood when the point arrived.
  assign in_stall = (cnt_r == 2'(QDepth)) ||
                    ((in_data.action == ActLoad) && (q_valid || mac_busy));
  assign acc = in_valid && !in_stall;
  assign push = acc && (in_data.action == ActXform);
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = q_mem_r[rp_r];

  always_comb begin
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_data.action == ActLoad) mat_r[in_data.coef_index] <= in_data.coef_value;
    if (push) q_mem_r[wp_r] <= '{x: in_data.in_x, y: in_data.in_y, z: in_data.in_z};
    rd_data <= mat_r[rd_idx];
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'(QDepth))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> (wp_r == rp_r))
    else $error("empty queue with unequal pointers");

endmodule

FILE: hw/rtl/vtd_engine.sv
// Compute engine: 12 serial multiply-accumulates, then three restoring divides.
module vtd_engine #(
  parameter int unsigned FRAC_BITS = vtd_pkg::FracBitsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  vtd_pkg::vtd_pt_t  q_data,
  output logic              mac_busy,
  output logic [3:0]        rd_idx,
  input  logic signed [31:0] rd_data,
  output logic              out_valid,
  input  logic              out_stall,
  output vtd_pkg::vtd_out_t out_data
);
  import vtd_pkg::*;

  localparam int unsigned QW = 32 + FRAC_BITS;
  localparam int unsigned SW = $clog2(QW + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MAC  = 5'b00010,
    S_DIVS = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } st_t;

  st_t st_r, st_nxt;
  vtd_pt_t pt_r;
  logic signed [31:0] hom_r [4];
  logic signed [33:0] acc_r;
  logic [1:0] row_r, drow_r;
  logic [1:0] col_r;
  logic [QW-1:0] dq_r;
  logic [32:0] drem_r, dden_r;
  logic [SW-1:0] dcnt_r;
  logic dneg_r;
  logic signed [31:0] proj_r [3];
  logic [33:0] rsh;
  logic signed [QW:0] qs;
  logic signed [31:0] qsat;
  logic issued_r;
  logic [1:0] ucol_r;
  logic [1:0] urow_r;
  logic signed [63:0] pu;
  logic signed [31:0] mua;
  logic signed [63:0] flu;
  logic signed [33:0] sumu;
  logic [31:0] nabs, dabs;

  // Read order: col 3 (translation) then cols 0..2 for row r, index = col*4+row.
  assign rd_idx = {col_r, row_r};
  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign out_valid = (st_r == S_OUT);
  assign mac_busy = (st_r == S_MAC);

  always_comb begin
    rsh = {drem_r, dq_r[QW-1]} - {1'b0, dden_r};
    qs = dneg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});
    qsat = sat32(66'(qs));
  end

  // The store read is registered: each MAC cycle issues the next address and
  // consumes the data of the address issued in the cycle before.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (q_valid) st_nxt = S_MAC;
      S_MAC:  if (issued_r && ucol_r == 2'd2 && urow_r == 2'd3) st_nxt = S_DIVS;
      S_DIVS: st_nxt = S_DIV;
      S_DIV:  if (dcnt_r == '0 && drow_r == 2'd2) st_nxt = S_OUT;
      S_OUT:  if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    unique case (ucol_r)
      2'd0: mua = pt_r.x;
      2'd1: mua = pt_r.y;
      default: mua = pt_r.z;
    endcase
    pu = 64'(mua) * 64'(rd_data);
    flu = pu >>> FRAC_BITS;
    sumu = acc_r + 34'(sat32(66'(flu)));
  end

  always_comb begin
    nabs = hom_r[drow_r][31] ? 32'(-hom_r[drow_r]) : 32'(hom_r[drow_r]);
    dabs = hom_r[3][31] ? 32'(-hom_r[3]) : 32'(hom_r[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    unique case (st_r)
      S_IDLE: begin
        pt_r <= q_data;
        col_r <= 2'd3;
        row_r <= 2'd0;
        issued_r <= 1'b0;
      end
      S_MAC: begin
        // Issue address for next step; consume data of the previous issue.
        issued_r <= 1'b1;
        ucol_r <= col_r;
        urow_r <= row_r;
        if (issued_r) begin
          if (ucol_r == 2'd3) acc_r <= 34'(rd_data);
          else if (ucol_r == 2'd2) hom_r[urow_r] <= sat32(66'(sumu));
          else acc_r <= sumu;
        end
        if (col_r == 2'd3) col_r <= 2'd0;
        else if (col_r == 2'd2) begin
          col_r <= 2'd3;
          row_r <= row_r + 2'd1;
        end else col_r <= col_r + 2'd1;
        drow_r <= 2'd0;
      end
      S_DIVS: begin
        dq_r <= {nabs, FRAC_BITS'(0)};
        drem_r <= '0;
        dden_r <= {1'b0, dabs};
        dneg_r <= hom_r[drow_r][31] ^ hom_r[3][31];
        dcnt_r <= SW'(QW);
      end
      S_DIV: begin
        if (dcnt_r != '0) begin
          if (!rsh[33]) begin
            drem_r <= rsh[32:0];
            dq_r <= {dq_r[QW-2:0], 1'b1};
          end else begin
            drem_r <= {drem_r[31:0], dq_r[QW-1]};
            dq_r <= {dq_r[QW-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r - SW'(1);
        end else begin
          proj_r[drow_r] <= (hom_r[3] == '0) ? Sat32Max : qsat;
          drow_r <= drow_r + 2'd1;
          dq_r <= {(hom_r[drow_r + 2'd1][31] ? 32'(-hom_r[drow_r + 2'd1])
                                             : 32'(hom_r[drow_r + 2'd1])), FRAC_BITS'(0)};
          drem_r <= '0;
          dneg_r <= hom_r[drow_r + 2'd1][31] ^ hom_r[3][31];
          dcnt_r <= SW'(QW);
        end
      end
      default: ;
    endcase
  end

  assign out_data = '{hom_x: hom_r[0], hom_y: hom_r[1], hom_z: hom_r[2], hom_w: hom_r[3],
                      proj_x: proj_r[0], proj_y: proj_r[1], proj_z: proj_r[2],
                      w_zero: (hom_r[3] == '0)};

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> $onehot(st_r))
    else $error("bad state");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> (st_r == S_MAC))
    else $error("pop did not start work");

endmodule

FILE: hw/rtl/vertex_transform_divide_core.sv
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | vtd_in_t
// out_    | output    | out_valid/out_stall| vtd_out_t
// A transform pops a point, runs serial multiply-accumulate on one multiplier,
// sets up the divider, runs one restoring division per projected coordinate and
// then holds the result in the output state while out_stall is high. A two-entry
// queue lets the front accept points while the engine works; a load stalls while
// a point is queued or reading the matrix.
// Reset clears control state; the matrix store is undefined until loaded.
module vertex_transform_divide_core #(
  parameter int unsigned FRAC_BITS = vtd_pkg::FracBitsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vtd_pkg::vtd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output vtd_pkg::vtd_out_t out_data
);
  import vtd_pkg::*;

  logic q_valid, q_pop, mac_busy;
  vtd_pt_t q_data;
  logic [3:0] rd_idx;
  logic signed [31:0] rd_data;

  vtd_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_pop, .q_data, .mac_busy, .rd_idx, .rd_data
  );

  vtd_engine #(.FRAC_BITS(FRAC_BITS)) u_engine (
    .clk, .rst_n, .q_valid, .q_pop, .q_data, .mac_busy, .rd_idx, .rd_data,
    .out_valid, .out_stall, .out_data
  );

endmodule
